[hw/rtl/utf8_stream_decoder_macros.svh]
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle, checked out of reset
`define UTF8SD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8sd check failed: implication broken");

// condition must never hold, checked out of reset
`define UTF8SD_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("utf8sd check failed: forbidden condition seen");

`endif

[hw/rtl/utf8sd_pkg.sv]
// shared types, constants and lead byte helpers for the utf8 stream decoder
package utf8sd_pkg;

	localparam int unsigned CP_W = 31;
	localparam int unsigned WID_W = 8;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 31'd63;
	localparam logic [WID_W-1:0] WIDTH_MAX = 8'd255;
	localparam logic [WID_W-1:0] WIDTH_ONE = 8'd1;

	// lead byte classes
	localparam logic [1:0] LEAD_ASCII = 2'd0;
	localparam logic [1:0] LEAD_MULTI = 2'd1;
	localparam logic [1:0] LEAD_BAD = 2'd2;

	// one decoded character
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic [WID_W-1:0] byte_width;
		logic malformed;
		logic last_of_run;
	} result_t;

	// what a lead byte tells
	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] value;
		logic [2:0] pending;
	} lead_t;

	// what one decode step hands to the result queue
	typedef struct packed {
		result_t res0;
		result_t res1;
		logic [1:0] count;
	} step_t;

	function automatic logic [WID_W-1:0] sat_inc(input logic [WID_W-1:0] w);
		sat_inc = (w == WIDTH_MAX) ? WIDTH_MAX : w + WIDTH_ONE;
	endfunction

	function automatic lead_t lead_decode(input logic [7:0] b);
		lead_t l;
		l = '{kind: LEAD_BAD, value: 5'd0, pending: 3'd0};
		if (b inside {[8'h00:8'h7F]}) begin
			l.kind = LEAD_ASCII;
		end else if (b inside {[8'hC0:8'hDF]}) begin
			l = '{kind: LEAD_MULTI, value: b[4:0], pending: 3'd1};
		end else if (b inside {[8'hE0:8'hEF]}) begin
			l = '{kind: LEAD_MULTI, value: {1'b0, b[3:0]}, pending: 3'd2};
		end else if (b inside {[8'hF0:8'hF7]}) begin
			l = '{kind: LEAD_MULTI, value: {2'b0, b[2:0]}, pending: 3'd3};
		end else if (b inside {[8'hF8:8'hFB]}) begin
			l = '{kind: LEAD_MULTI, value: {3'b0, b[1:0]}, pending: 3'd4};
		end else if (b inside {[8'hFC:8'hFD]}) begin
			l = '{kind: LEAD_MULTI, value: {4'b0, b[0]}, pending: 3'd5};
		end
		lead_decode = l;
	endfunction

endpackage

[hw/rtl/utf8sd_decode.sv]
// decoder state and the single-pass decode of one byte into up to two results
module utf8sd_decode
	import utf8sd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [7:0] data_byte,
	input  logic end_of_message,
	output step_t step
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_STRAY = 2'd1;
	localparam logic [1:0] PH_CONT = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [2:0] pend_q, pend_d;
	logic [CP_W-1:0] acc_q, acc_d;
	logic [WID_W-1:0] wid_q, wid_d;

	result_t res [2];
	logic [1:0] n;
	logic cont;
	logic do_boundary;
	logic do_lead;
	logic [WID_W-1:0] lead_w;
	lead_t li;

	assign cont = (data_byte[7:6] == 2'b10);
	assign li = lead_decode(data_byte);

	// next state and results for the byte in the input stage
	always_comb begin
		phase_d = phase_q;
		pend_d = pend_q;
		acc_d = acc_q;
		wid_d = wid_q;
		res[0] = '0;
		res[1] = '0;
		n = 2'd0;
		do_boundary = 1'b0;
		do_lead = 1'b0;
		lead_w = WIDTH_ONE;

		case (phase_q)
			PH_IDLE: begin
				do_boundary = 1'b1;
			end
			PH_STRAY: begin
				if (cont) begin
					wid_d = sat_inc(wid_q);
				end else begin
					do_lead = 1'b1;
					lead_w = sat_inc(wid_q);
				end
			end
			PH_CONT: begin
				if (cont) begin
					acc_d = {acc_q[CP_W-7:0], data_byte[5:0]};
					wid_d = sat_inc(wid_q);
					pend_d = pend_q - 3'd1;
					if (pend_d == 3'd0) begin
						res[n[0]] = '{acc_d, wid_d, 1'b0, 1'b0};
						n = n + 2'd1;
						phase_d = PH_IDLE;
					end
				end else begin
					// broken sequence, the byte then starts afresh
					res[n[0]] = '{REPLACEMENT_CP, wid_q, 1'b1, 1'b0};
					n = n + 2'd1;
					phase_d = PH_IDLE;
					do_boundary = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// byte seen at a character boundary
		if (do_boundary) begin
			if (data_byte == 8'd0) begin
				phase_d = PH_DONE;
			end else if (cont) begin
				phase_d = PH_STRAY;
				wid_d = WIDTH_ONE;
			end else begin
				do_lead = 1'b1;
				lead_w = WIDTH_ONE;
			end
		end

		// lead byte
		if (do_lead) begin
			case (li.kind)
				LEAD_ASCII: begin
					res[n[0]] = '{{{(CP_W-8){1'b0}}, data_byte}, lead_w, 1'b0, 1'b0};
					n = n + 2'd1;
					phase_d = PH_IDLE;
				end
				LEAD_MULTI: begin
					acc_d = {{(CP_W-5){1'b0}}, li.value};
					pend_d = li.pending;
					wid_d = lead_w;
					phase_d = PH_CONT;
				end
				default: begin
					res[n[0]] = '{REPLACEMENT_CP, lead_w, 1'b1, 1'b0};
					n = n + 2'd1;
					phase_d = PH_IDLE;
				end
			endcase
		end

		// end of message flushes a truncated character and clears state
		if (end_of_message) begin
			if (phase_d == PH_STRAY || phase_d == PH_CONT) begin
				res[n[0]] = '{REPLACEMENT_CP, wid_d, 1'b1, 1'b0};
				n = n + 2'd1;
			end
			phase_d = PH_IDLE;
			pend_d = 3'd0;
			acc_d = '0;
			wid_d = '0;
		end

		// mark the final result of this byte
		if (n == 2'd2) begin
			res[1].last_of_run = 1'b1;
		end else if (n == 2'd1) begin
			res[0].last_of_run = 1'b1;
		end
	end

	assign step = '{res0: res[0], res1: res[1], count: advance ? n : 2'd0};

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pend_q <= 3'd0;
			acc_q <= '0;
			wid_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pend_q <= pend_d;
			acc_q <= acc_d;
			wid_q <= wid_d;
		end
	end

endmodule

[hw/rtl/utf8sd_result_fifo.sv]
// small result queue taking up to two results a cycle and giving one
module utf8sd_result_fifo
	import utf8sd_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  step_t step,
	input  logic pop,
	output result_t head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH+1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH-1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
	endfunction

	result_t mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_next;
	logic [CW-1:0] count_q;

	assign wr_next = ptr_inc(wr_q);
	assign head = mem[rd_q];
	assign count = count_q;

	// result storage
	always_ff @(posedge clk) begin
		if (step.count != 2'd0) begin
			mem[wr_q] <= step.res0;
		end
		if (step.count == 2'd2) begin
			mem[wr_next] <= step.res1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (step.count == 2'd1) begin
				wr_q <= wr_next;
			end else if (step.count == 2'd2) begin
				wr_q <= ptr_inc(wr_next);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			count_q <= count_q + CW'(step.count) - CW'(pop);
		end
	end

endmodule

[hw/rtl/utf8_stream_decoder.sv]
// top level of the streaming utf8 decoder (legacy one to six byte form)
//
//  channel | handshake              | payload
//  byte    | byte_valid, byte_stall | data_byte, end_of_message
//  char    | char_valid, char_stall | code_point, byte_width, malformed, last_of_run
//
// one byte is taken per cycle while byte_stall is low; it waits in the input stage
// until the decoder advances; its results are registered in the result queue and
// offered on the char side one result per cycle while char_stall is low, two at most.
// the rate is set by the result queue: a byte is decoded only when it has room
// for two results, so a stalled char side backs up into the byte side.
// reset clears the decoder state and the queue; the next byte is at a boundary.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder
	import utf8sd_pkg::*;
#(
	parameter int unsigned RESULT_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_stall,
	input  logic [7:0] data_byte,
	input  logic end_of_message,
	output logic char_valid,
	input  logic char_stall,
	output logic [CP_W-1:0] code_point,
	output logic [WID_W-1:0] byte_width,
	output logic malformed,
	output logic last_of_run
);

	localparam int unsigned CW = $clog2(RESULT_DEPTH+1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(RESULT_DEPTH-2);
	localparam logic [CW-1:0] DEPTH_C = CW'(RESULT_DEPTH);

	logic valid_s1;
	logic [7:0] data_s1;
	logic eom_s1;
	logic room;
	logic advance;
	logic pop;
	step_t step;
	result_t head;
	logic [CW-1:0] fifo_count;

	assign room = (fifo_count <= ROOM_LIMIT);
	assign advance = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign char_valid = (fifo_count != '0);
	assign pop = char_valid && !char_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			eom_s1 <= end_of_message;
		end
	end

	// decode step
	utf8sd_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.data_byte      (data_s1),
		.end_of_message (eom_s1),
		.step           (step)
	);

	// result queue
	utf8sd_result_fifo #(
		.DEPTH (RESULT_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pop    (pop),
		.head   (head),
		.count  (fifo_count)
	);

	assign code_point = head.code_point;
	assign byte_width = head.byte_width;
	assign malformed = head.malformed;
	assign last_of_run = head.last_of_run;

	// checks
	`UTF8SD_ASSERT_NEVER(a_queue_overflow, fifo_count > DEPTH_C)
	`UTF8SD_ASSERT_IMPLY(a_pair_last, step.count == 2'd2, !step.res0.last_of_run && step.res1.last_of_run)
	`UTF8SD_ASSERT_IMPLY(a_single_last, step.count == 2'd1, step.res0.last_of_run)
	`UTF8SD_ASSERT_IMPLY(a_push_needs_room, step.count != 2'd0, fifo_count <= ROOM_LIMIT)

endmodule
